@@ rtl/assert_macros.svh @@
// assertion macros shared by the deframer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked on every rising edge out of reset
`define AFRD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define AFRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define AFRD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define AFRD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/afrd_pkg.sv @@
// types and constants for the api frame receive deframer
`timescale 1ns / 1ps
`default_nettype none

package afrd_pkg;

    // largest frame, delimiter and length and checksum included
    localparam int MAX_FRAME_BYTES = 256;

    // longest payload length that still fits a frame
    localparam logic [7:0] LEN_LIMIT = 8'(MAX_FRAME_BYTES - 4);

    localparam logic [7:0] DELIM_RESET = 8'h7E;
    localparam logic [7:0] SUM_BASE    = 8'hFF;

    // position of the two length bytes after the delimiter
    localparam logic [7:0] POS_LEN_HIGH = 8'd0;
    localparam logic [7:0] POS_LEN_LOW  = 8'd1;
    localparam logic [7:0] POS_PAYLOAD  = 8'd2;

    typedef enum logic [1:0] {
        ST_PAYLOAD  = 2'd0,
        ST_GOOD     = 2'd1,
        ST_BAD_SUM  = 2'd2,
        ST_TOO_LONG = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] payload_offset;
        logic       end_of_frame;
        t_status    frame_status;
    } t_result;

    typedef struct packed {
        logic    has_result;
        t_result result;
    } t_core_out;

endpackage

`default_nettype wire

@@ rtl/afrd_ifs.sv @@
// valid/ready channel interfaces for received bytes and deframed results
`timescale 1ns / 1ps
`default_nettype none

interface afrd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface afrd_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [7:0] payload_offset;
    logic       end_of_frame;
    logic [1:0] frame_status;

    modport source (
        output valid, output data_byte, output payload_offset,
        output end_of_frame, output frame_status, input ready
    );
    modport sink (
        input valid, input data_byte, input payload_offset,
        input end_of_frame, input frame_status, output ready
    );
endinterface

`default_nettype wire

@@ rtl/afrd_in_reg.sv @@
// input register holding one received byte
`timescale 1ns / 1ps
`default_nettype none

module afrd_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    afrd_rx_if.sink    i_rx,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte
);
    import afrd_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;

    // refill in the same cycle the held byte is consumed
    assign i_rx.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

`default_nettype wire

@@ rtl/afrd_core.sv @@
// frame state, length capture and checksum check
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module afrd_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [7:0]          i_cfg_wr_data,
    input  logic                i_fire,
    input  logic [7:0]          i_byte,
    output afrd_pkg::t_core_out o_out
);
    import afrd_pkg::*;

    logic [7:0] r_delim_val;
    logic       r_in_frame, n_in_frame;
    logic [7:0] r_pos, n_pos;
    logic [7:0] r_len_high, n_len_high;
    logic [7:0] r_len, n_len;
    logic [7:0] r_sum, n_sum;
    logic [7:0] w_offset;
    logic [7:0] w_expect;
    logic       w_too_long;

    assign w_offset   = r_pos - POS_PAYLOAD;
    assign w_expect   = SUM_BASE - r_sum;
    assign w_too_long = (r_len_high != 8'd0) || (i_byte > LEN_LIMIT);

    always_comb begin
        n_in_frame = r_in_frame;
        n_pos      = r_pos;
        n_len_high = r_len_high;
        n_len      = r_len;
        n_sum      = r_sum;
        o_out      = '0;

        if (!r_in_frame) begin
            if (i_byte == r_delim_val) begin
                n_in_frame = 1'b1;
                n_pos      = POS_LEN_HIGH;
                n_len_high = 8'd0;
                n_len      = 8'd0;
                n_sum      = 8'd0;
            end
        end else if (r_pos == POS_LEN_HIGH) begin
            n_len_high = i_byte;
            n_pos      = POS_LEN_LOW;
        end else if (r_pos == POS_LEN_LOW) begin
            if (w_too_long) begin
                o_out.has_result            = 1'b1;
                o_out.result.data_byte      = i_byte;
                o_out.result.payload_offset = 8'd0;
                o_out.result.end_of_frame   = 1'b1;
                o_out.result.frame_status   = ST_TOO_LONG;
                n_in_frame                  = 1'b0;
                n_pos                       = POS_LEN_HIGH;
            end else begin
                n_len = i_byte;
                n_sum = 8'd0;
                n_pos = POS_PAYLOAD;
            end
        end else begin
            o_out.has_result            = 1'b1;
            o_out.result.data_byte      = i_byte;
            o_out.result.payload_offset = w_offset;
            if (w_offset == r_len) begin
                // checksum byte closes the frame
                o_out.result.end_of_frame = 1'b1;
                o_out.result.frame_status = (i_byte == w_expect) ? ST_GOOD : ST_BAD_SUM;
                n_in_frame                = 1'b0;
                n_pos                     = POS_LEN_HIGH;
            end else begin
                o_out.result.end_of_frame = 1'b0;
                o_out.result.frame_status = ST_PAYLOAD;
                n_sum                     = r_sum + i_byte;
                n_pos                     = r_pos + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim_val <= DELIM_RESET;
            r_in_frame  <= 1'b0;
            r_pos       <= 8'd0;
            r_len_high  <= 8'd0;
            r_len       <= 8'd0;
            r_sum       <= 8'd0;
        end else begin
            if (i_cfg_wr_en) begin
                r_delim_val <= i_cfg_wr_data;
            end
            if (i_fire) begin
                r_in_frame <= n_in_frame;
                r_pos      <= n_pos;
                r_len_high <= n_len_high;
                r_len      <= n_len;
                r_sum      <= n_sum;
            end
        end
    end

    // a delimiter write lands in the register on the next edge
    `AFRD_ASSERT_NEXT(a_cfg_lands, i_clk, i_rst_n, i_cfg_wr_en, r_delim_val == $past(i_cfg_wr_data))
    `AFRD_ASSERT_NEXT(a_eof_hunts, i_clk, i_rst_n, i_fire && o_out.has_result && o_out.result.end_of_frame, !r_in_frame && (r_pos == POS_LEN_HIGH))
    `AFRD_ASSERT_IMPLIES(a_off_bound, i_clk, i_rst_n, r_in_frame && (r_pos >= POS_PAYLOAD), w_offset <= r_len)
    `AFRD_ASSERT_IMPLIES(a_len_fits, i_clk, i_rst_n, r_in_frame && (r_pos >= POS_PAYLOAD), r_len <= LEN_LIMIT)

endmodule

`default_nettype wire

@@ rtl/afrd_out_reg.sv @@
// result register feeding the output channel
`timescale 1ns / 1ps
`default_nettype none

module afrd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  afrd_pkg::t_result i_result,
    output logic              o_free,
    afrd_res_if.source        o_res
);
    import afrd_pkg::*;

    logic    r_valid;
    t_result r_res;

    // free when empty or when the held transaction leaves this cycle
    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_res <= i_result;
        end
    end

    assign o_res.valid          = r_valid;
    assign o_res.data_byte      = r_res.data_byte;
    assign o_res.payload_offset = r_res.payload_offset;
    assign o_res.end_of_frame   = r_res.end_of_frame;
    assign o_res.frame_status   = r_res.frame_status;

endmodule

`default_nettype wire

@@ rtl/api_frame_receive_deframer_unit.sv @@
// Receive deframer for API frames: hunts for the start delimiter (register,
// reset 0x7E), takes a two-byte big-endian payload length, passes each payload
// byte out with its offset and checks the closing checksum byte against 0xFF
// minus the 8-bit payload sum. Bytes outside a frame give no transaction; the
// two length bytes give none unless the length is too long for a frame of
// MAX_FRAME_BYTES, which gives one end-of-frame transaction with status 3.
// One byte is taken per clock cycle unless the input register is held; a byte
// that gives a result passes through the input register and then the result
// register before it shows on the result channel. While a result waits on the
// output side, a held byte that also gives a result holds the input register;
// bytes without a result pass regardless. No clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module api_frame_receive_deframer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    afrd_rx_if.sink    i_rx,
    afrd_res_if.source o_res
);
    import afrd_pkg::*;

    logic       w_held_valid;
    logic [7:0] w_held_byte;
    logic       w_out_free;
    logic       w_take;
    t_core_out  w_core;

    // a byte without a result never waits on the output side
    assign w_take = w_held_valid && (!w_core.has_result || w_out_free);

    afrd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_take  (w_take),
        .o_valid (w_held_valid),
        .o_byte  (w_held_byte)
    );

    afrd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_fire        (w_take),
        .i_byte        (w_held_byte),
        .o_out         (w_core)
    );

    afrd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_take && w_core.has_result),
        .i_result (w_core.result),
        .o_free   (w_out_free),
        .o_res    (o_res)
    );

endmodule

`default_nettype wire

@@ dv/api_frame_receive_deframer_unit_tb.sv @@
// testbench for the api frame receive deframer: directed rows, then random frames and noise
`timescale 1ns / 1ps

module api_frame_receive_deframer_unit_tb;
    import afrd_pkg::*;

    typedef struct {
        logic [7:0] rx;
        bit         fixed;
        bit         has;
        t_result    res;
    } t_stim_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    afrd_rx_if  rx_if();
    afrd_res_if res_if();

    api_frame_receive_deframer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_rx          (rx_if),
        .o_res         (res_if)
    );

    // deframer state as the predictor sees it
    logic [7:0] delim_q;
    bit         in_frame;
    logic [7:0] frame_pos;
    logic [7:0] len_high;
    logic [7:0] pay_len;
    logic [7:0] pay_sum;

    t_result    frame_results_q[$];
    int         errors;
    int         bytes_sent;
    bit         calm_mode;

    always #4 i_clk = ~i_clk;

    function automatic int draw_wait();
        return calm_mode ? 0 : $urandom_range(0, 13);
    endfunction

    // one received byte through the deframer; returns 1 when it gives a result
    function automatic bit deframe_step(input logic [7:0] b, output t_result r);
        logic [15:0] full_len;
        logic [7:0]  offset;
        r = '0;
        if (!in_frame) begin
            if (b == delim_q) begin
                in_frame  = 1'b1;
                frame_pos = POS_LEN_HIGH;
                len_high  = 8'h00;
                pay_len   = 8'h00;
                pay_sum   = 8'h00;
            end
            return 1'b0;
        end
        if (frame_pos == POS_LEN_HIGH) begin
            len_high  = b;
            frame_pos = POS_LEN_LOW;
            return 1'b0;
        end
        if (frame_pos == POS_LEN_LOW) begin
            full_len = {len_high, b};
            if (int'(full_len) + 4 > MAX_FRAME_BYTES) begin
                r.data_byte      = b;
                r.payload_offset = 8'h00;
                r.end_of_frame   = 1'b1;
                r.frame_status   = ST_TOO_LONG;
                in_frame  = 1'b0;
                frame_pos = POS_LEN_HIGH;
                return 1'b1;
            end
            pay_len   = b;
            pay_sum   = 8'h00;
            frame_pos = POS_PAYLOAD;
            return 1'b0;
        end
        offset = frame_pos - POS_PAYLOAD;
        r.data_byte      = b;
        r.payload_offset = offset;
        if (offset == pay_len) begin
            r.end_of_frame = 1'b1;
            r.frame_status = (b == 8'(SUM_BASE - pay_sum)) ? ST_GOOD : ST_BAD_SUM;
            in_frame  = 1'b0;
            frame_pos = POS_LEN_HIGH;
            return 1'b1;
        end
        pay_sum   = pay_sum + b;
        frame_pos = frame_pos + 8'd1;
        r.end_of_frame = 1'b0;
        r.frame_status = ST_PAYLOAD;
        return 1'b1;
    endfunction

    function automatic t_stim_row stim_row(input logic [7:0] b, input bit fixed, input bit has,
                                           input logic [7:0] d, input logic [7:0] off,
                                           input logic eof, input t_status st);
        t_stim_row r;
        r.rx    = b;
        r.fixed = fixed;
        r.has   = has;
        r.res.data_byte      = d;
        r.res.payload_offset = off;
        r.res.end_of_frame   = eof;
        r.res.frame_status   = st;
        return r;
    endfunction

    // leaves valid high after the transaction; release_rx, or the next call when it draws a gap, lowers it
    task automatic send_byte(input t_stim_row r);
        int      gap;
        t_result pred;
        bit      pred_has;
        gap = draw_wait();
        @(negedge i_clk);
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= r.rx;
        do @(posedge i_clk); while (rx_if.ready !== 1'b1);
        bytes_sent++;
        pred_has = deframe_step(r.rx, pred);
        if (r.fixed) begin
            pred_has = r.has;
            pred     = r.res;
        end
        if (pred_has)
            frame_results_q.push_back(pred);
    endtask

    task automatic send_plain(input logic [7:0] b);
        send_byte(stim_row(b, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0, ST_PAYLOAD));
    endtask

    task automatic release_rx();
        @(negedge i_clk);
        rx_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (frame_results_q.size() != 0)
            @(posedge i_clk);
        // bytes that give no result may still sit in the pipeline
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_delim(input logic [7:0] v);
        release_rx();
        wait_drained();
        @(negedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
        delim_q = v;
    endtask

    task automatic run_phase(input logic [7:0] delim_val, input int quota);
        int          stop_at;
        int          kind;
        int          n;
        int          flen;
        int          cut;
        logic [7:0]  sum;
        logic [7:0]  b;
        write_delim(delim_val);
        stop_at = bytes_sent + quota;
        while (bytes_sent < stop_at) begin
            calm_mode = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 10) begin
                n = $urandom_range(1, 6);
                repeat (n) send_plain(8'($urandom_range(0, 255)));
            end else begin
                kind = $urandom_range(0, 99);
                if (kind < 6)
                    flen = $urandom_range(253, 65535);
                else if (kind < 8)
                    flen = $urandom_range(200, 252);
                else if (kind < 16)
                    flen = 0;
                else
                    flen = $urandom_range(1, 12);
                send_plain(delim_q);
                send_plain(8'(flen >> 8));
                send_plain(8'(flen));
                if (flen <= 252) begin
                    // a cut frame lets the next bytes run on as payload
                    cut = ($urandom_range(0, 99) < 8) ? $urandom_range(0, flen) : flen + 1;
                    sum = 8'h00;
                    for (int i = 0; i < flen && i < cut; i++) begin
                        b = ($urandom_range(0, 15) == 0) ? delim_q : 8'($urandom_range(0, 255));
                        sum = sum + b;
                        send_plain(b);
                    end
                    if (cut > flen) begin
                        if ($urandom_range(0, 3) != 0)
                            send_plain(8'(SUM_BASE - sum));
                        else
                            send_plain(8'($urandom_range(0, 255)));
                    end
                end
            end
        end
        calm_mode = 1'b0;
    endtask

    // result side: random stall before each transaction
    initial begin
        int stall;
        res_if.ready = 1'b0;
        forever begin
            stall = draw_wait();
            @(negedge i_clk);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (res_if.valid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            got.data_byte      = res_if.data_byte;
            got.payload_offset = res_if.payload_offset;
            got.end_of_frame   = res_if.end_of_frame;
            got.frame_status   = t_status'(res_if.frame_status);
            if (frame_results_q.size() == 0) begin
                $display("%0t: unexpected transaction, actual %h/%h/%b/%0d", $time,
                         got.data_byte, got.payload_offset, got.end_of_frame,
                         got.frame_status);
                errors++;
            end else begin
                want = frame_results_q.pop_front();
                if (got.data_byte !== want.data_byte) begin
                    $display("%0t: data_byte expected %h actual %h", $time,
                             want.data_byte, got.data_byte);
                    errors++;
                end
                if (got.payload_offset !== want.payload_offset) begin
                    $display("%0t: payload_offset expected %0d actual %0d", $time,
                             want.payload_offset, got.payload_offset);
                    errors++;
                end
                if (got.end_of_frame !== want.end_of_frame) begin
                    $display("%0t: end_of_frame expected %b actual %b", $time,
                             want.end_of_frame, got.end_of_frame);
                    errors++;
                end
                if (got.frame_status !== want.frame_status) begin
                    $display("%0t: frame_status expected %0d actual %0d", $time,
                             want.frame_status, got.frame_status);
                    errors++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("api_frame_receive_deframer_unit_tb failed");
        $finish;
    end

    initial begin
        t_stim_row rows[$];
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 8'h00;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = 8'h00;
        errors        = 0;
        bytes_sent    = 0;
        calm_mode     = 1'b0;
        delim_q       = DELIM_RESET;
        in_frame      = 1'b0;
        frame_pos     = POS_LEN_HIGH;
        len_high      = 8'h00;
        pay_len       = 8'h00;
        pay_sum       = 8'h00;

        // noise while hunting, then a zero-length good frame
        rows.push_back(stim_row(8'h00, 1, 0, 8'h00, 8'h00, 0, ST_PAYLOAD));
        rows.push_back(stim_row(8'hFF, 1, 0, 8'h00, 8'h00, 0, ST_PAYLOAD));
        rows.push_back(stim_row(8'h7E, 1, 0, 8'h00, 8'h00, 0, ST_PAYLOAD));
        rows.push_back(stim_row(8'h00, 1, 0, 8'h00, 8'h00, 0, ST_PAYLOAD));
        rows.push_back(stim_row(8'h00, 1, 0, 8'h00, 8'h00, 0, ST_PAYLOAD));
        rows.push_back(stim_row(8'hFF, 1, 1, 8'hFF, 8'h00, 1, ST_GOOD));
        // zero length with a bad checksum
        rows.push_back(stim_row(8'h7E, 1, 0, 8'h00, 8'h00, 0, ST_PAYLOAD));
        rows.push_back(stim_row(8'h00, 1, 0, 8'h00, 8'h00, 0, ST_PAYLOAD));
        rows.push_back(stim_row(8'h00, 1, 0, 8'h00, 8'h00, 0, ST_PAYLOAD));
        rows.push_back(stim_row(8'h00, 1, 1, 8'h00, 8'h00, 1, ST_BAD_SUM));
        // length 256 and length 253 are both too long
        rows.push_back(stim_row(8'h7E, 1, 0, 8'h00, 8'h00, 0, ST_PAYLOAD));
        rows.push_back(stim_row(8'h01, 1, 0, 8'h00, 8'h00, 0, ST_PAYLOAD));
        rows.push_back(stim_row(8'h00, 1, 1, 8'h00, 8'h00, 1, ST_TOO_LONG));
        rows.push_back(stim_row(8'h7E, 1, 0, 8'h00, 8'h00, 0, ST_PAYLOAD));
        rows.push_back(stim_row(8'h00, 1, 0, 8'h00, 8'h00, 0, ST_PAYLOAD));
        rows.push_back(stim_row(8'hFD, 1, 1, 8'hFD, 8'h00, 1, ST_TOO_LONG));
        // two payload bytes, the first one equal to the delimiter
        rows.push_back(stim_row(8'h7E, 1, 0, 8'h00, 8'h00, 0, ST_PAYLOAD));
        rows.push_back(stim_row(8'h00, 1, 0, 8'h00, 8'h00, 0, ST_PAYLOAD));
        rows.push_back(stim_row(8'h02, 1, 0, 8'h00, 8'h00, 0, ST_PAYLOAD));
        rows.push_back(stim_row(8'h7E, 0, 0, 8'h00, 8'h00, 0, ST_PAYLOAD));
        rows.push_back(stim_row(8'h55, 0, 0, 8'h00, 8'h00, 0, ST_PAYLOAD));
        rows.push_back(stim_row(8'h2C, 1, 1, 8'h2C, 8'h02, 1, ST_GOOD));

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i])
            send_byte(rows[i]);

        run_phase(8'h00, 225);
        run_phase(8'hFF, 225);
        run_phase(8'($urandom_range(0, 255)), 225);
        run_phase(DELIM_RESET, 225);

        release_rx();
        while (frame_results_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("api_frame_receive_deframer_unit_tb passed");
        else
            $display("api_frame_receive_deframer_unit_tb failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/afrd_pkg.sv
rtl/afrd_ifs.sv
rtl/afrd_in_reg.sv
rtl/afrd_core.sv
rtl/afrd_out_reg.sv
rtl/api_frame_receive_deframer_unit.sv
dv/api_frame_receive_deframer_unit_tb.sv
